>>> rtl/spfa_pkg.sv
// Package with pipeline stage types and constants for the binary32 adder.
`timescale 1ns / 1ps

package spfa_pkg;

   localparam logic [7:0]  EXP_MAX      = 8'hFF;
   localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
   localparam logic [31:0] INF_PACKED   = 32'h7F80_0000;

   // Operands decoded, ordered by magnitude, exponent difference known.
   typedef struct packed {
      logic        valid;
      logic        special;
      logic [31:0] spec_val;
      logic        sign;
      logic [7:0]  xa;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [7:0]  diff;
      logic        sub;
   } stage1_type;

   // Raw sum with guard, round and sticky bits.
   typedef struct packed {
      logic        valid;
      logic        special;
      logic [31:0] spec_val;
      logic        sign;
      logic [7:0]  xa;
      logic [27:0] sum;
   } stage2_type;

   // Normalized significand and encoded exponent.
   typedef struct packed {
      logic        valid;
      logic        special;
      logic [31:0] spec_val;
      logic        sign;
      logic        zero;
      logic        normal;
      logic [7:0]  eenc;
      logic [27:0] norm;
   } stage3_type;

endpackage

>>> rtl/single_precision_float_adder.sv
// Pipelined IEEE 754 binary32 adder, round to nearest even.
`timescale 1ns / 1ps

// Channel   Direction  Payload
// req       in         tdata[31:0] addend_a, tdata[63:32] addend_b
// rsp       out        tdata[31:0] sum_bits
//
// A request is taken every cycle unless the pipeline holds; its sum leaves from the result register.
// The stages are decode/order, align/add, leading-zero normalize, round/pack.
// The whole pipeline holds while a result waits and rsp_tready is low.
// Reset clears only the stage valid bits.
module single_precision_float_adder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // addend_a [31:0], addend_b [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // sum_bits [31:0]
);

   spfa_pkg::stage1_type s1_ff, s1_in;
   spfa_pkg::stage2_type s2_ff, s2_in;
   spfa_pkg::stage3_type s3_ff, s3_in;
   logic                 out_valid_ff, out_valid_in;
   logic [31:0]          out_data_ff, out_data_in;
   logic                 advance;

   // The pipeline moves as a whole unless the result register is blocked.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Stage 1: decode, handle special operands, order by magnitude.
   always_comb begin
      logic [31:0] a, b;
      logic        sa, sb, nan_a, nan_b, inf_a, inf_b, za, zb, swap;
      logic [7:0]  ea, eb, xa, xb;
      logic [23:0] ma, mb;
      a     = req_tdata[31:0];
      b     = req_tdata[63:32];
      sa    = a[31];
      sb    = b[31];
      ea    = a[30:23];
      eb    = b[30:23];
      nan_a = (ea == spfa_pkg::EXP_MAX) && (a[22:0] != 23'd0);
      nan_b = (eb == spfa_pkg::EXP_MAX) && (b[22:0] != 23'd0);
      inf_a = (ea == spfa_pkg::EXP_MAX) && (a[22:0] == 23'd0);
      inf_b = (eb == spfa_pkg::EXP_MAX) && (b[22:0] == 23'd0);
      za    = (ea == 8'd0) && (a[22:0] == 23'd0);
      zb    = (eb == 8'd0) && (b[22:0] == 23'd0);
      ma    = {(ea != 8'd0), a[22:0]};
      mb    = {(eb != 8'd0), b[22:0]};
      xa    = (ea != 8'd0) ? ea : 8'd1;
      xb    = (eb != 8'd0) ? eb : 8'd1;
      swap  = {xb, mb} > {xa, ma};

      s1_in          = '0;
      s1_in.valid    = req_tvalid;
      s1_in.special  = 1'b1;
      s1_in.spec_val = a;
      if (nan_a) begin
         s1_in.spec_val = a;
      end else if (nan_b) begin
         s1_in.spec_val = b;
      end else if (inf_a && inf_b) begin
         s1_in.spec_val = (sa != sb) ? spfa_pkg::QNAN_DEFAULT : a;
      end else if (inf_a) begin
         s1_in.spec_val = a;
      end else if (inf_b) begin
         s1_in.spec_val = b;
      end else if (za && zb) begin
         s1_in.spec_val = {(sa & sb), 31'd0};
      end else if (za) begin
         s1_in.spec_val = b;
      end else if (zb) begin
         s1_in.spec_val = a;
      end else begin
         s1_in.special = 1'b0;
      end
      s1_in.sub  = sa ^ sb;
      s1_in.sign = swap ? sb : sa;
      s1_in.xa   = swap ? xb : xa;
      s1_in.ma   = swap ? mb : ma;
      s1_in.mb   = swap ? ma : mb;
      s1_in.diff = swap ? (xb - xa) : (xa - xb);
   end

   // Stage 2: align the smaller operand with sticky, then add or subtract.
   always_comb begin
      logic [26:0] ext_a, ext_b, aligned, lost;
      logic [4:0]  sh;
      ext_a = {s1_ff.ma, 3'b000};
      ext_b = {s1_ff.mb, 3'b000};
      sh    = s1_ff.diff[4:0];
      lost  = ext_b & ~({27{1'b1}} << sh);
      if (s1_ff.diff >= 8'd27) begin
         aligned = {26'd0, (ext_b != 27'd0)};
      end else begin
         aligned = (ext_b >> sh) | {26'd0, (lost != 27'd0)};
      end
      s2_in          = '0;
      s2_in.valid    = s1_ff.valid;
      s2_in.special  = s1_ff.special;
      s2_in.spec_val = s1_ff.spec_val;
      s2_in.sign     = s1_ff.sign;
      s2_in.xa       = s1_ff.xa;
      s2_in.sum      = s1_ff.sub ? ({1'b0, ext_a} - {1'b0, aligned})
                                 : ({1'b0, ext_a} + {1'b0, aligned});
   end

   // Stage 3: count leading zeros and normalize, clamping at the subnormal range.
   always_comb begin
      logic [4:0] lz, sh;
      logic       normal;
      lz = 5'd0;
      for (int i = 0; i < 28; i++) begin
         if (s2_ff.sum[i]) begin
            lz = 5'(27 - i);
         end
      end
      normal = ({3'b000, lz} <= s2_ff.xa);
      sh     = normal ? lz : s2_ff.xa[4:0];
      s3_in          = '0;
      s3_in.valid    = s2_ff.valid;
      s3_in.special  = s2_ff.special;
      s3_in.spec_val = s2_ff.spec_val;
      s3_in.sign     = s2_ff.sign;
      s3_in.zero     = (s2_ff.sum == 28'd0);
      s3_in.normal   = normal;
      s3_in.eenc     = normal ? (s2_ff.xa - {3'b000, lz}) : 8'd0;
      s3_in.norm     = s2_ff.sum << sh;
   end

   // Stage 4: round to nearest even, pack, and saturate to infinity.
   always_comb begin
      logic [23:0] mant;
      logic        round_inc;
      logic [31:0] packed_val;
      mant       = s3_ff.norm[27:4];
      round_inc  = s3_ff.norm[3] && ((s3_ff.norm[2:0] != 3'd0) || mant[0]);
      packed_val = {1'b0, s3_ff.eenc, 23'd0} + {8'd0, mant} + {31'd0, round_inc};
      out_valid_in = s3_ff.valid;
      if (s3_ff.special) begin
         out_data_in = s3_ff.spec_val;
      end else if (s3_ff.zero) begin
         out_data_in = 32'd0;
      end else if (packed_val >= spfa_pkg::INF_PACKED) begin
         out_data_in = {s3_ff.sign, spfa_pkg::INF_PACKED[30:0]};
      end else begin
         out_data_in = {s3_ff.sign, packed_val[30:0]};
      end
   end

   // Pipeline registers; payload holds with the valid bits on a stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef SYNTHESIS
   // A normal, nonzero result has its leading one at the top after the shift.
   a_norm_lead : assert property (@(posedge clock) disable iff (reset)
      (s3_ff.valid && !s3_ff.special && !s3_ff.zero && s3_ff.normal) |-> s3_ff.norm[27])
      else $error("normalized significand lacks leading one");

   // A blocked result freezes the first stage too.
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(s1_ff) && $stable(s3_ff))
      else $error("pipeline moved during a stall");

   // A subnormal result keeps its top significand bit clear before rounding.
   a_subnormal : assert property (@(posedge clock) disable iff (reset)
      (s3_ff.valid && !s3_ff.special && !s3_ff.normal)
         |-> (s3_ff.eenc == 8'd0) && !s3_ff.norm[27])
      else $error("subnormal result with hidden bit set");

   // Nothing is valid right after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_ff.valid && !s2_ff.valid && !s3_ff.valid)
      else $error("pipeline not empty after reset");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the pipelined binary32 adder.
`timescale 1ns / 1ps

module tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // addend_a [31:0], addend_b [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // sum_bits [31:0]

   logic [31:0] sum_queue[$];
   int          mismatch_count;
   int          sum_count;
   int          sent_count;
   bit          stall_enable;

   single_precision_float_adder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with a 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Correctly rounded binary32 sum, nearest even.
   function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
      logic        sa, sb, ts, sgn;
      logic [7:0]  ea, eb;
      logic [22:0] fa, fb;
      logic [63:0] ma, mb, tm, lost, r, rem, half, m, packed_val;
      int          xa, xb, tx, d, p, e, s;
      logic [31:0] eenc;
      sa = a[31];
      sb = b[31];
      ea = a[30:23];
      eb = b[30:23];
      fa = a[22:0];
      fb = b[22:0];
      if (ea == spfa_pkg::EXP_MAX && fa != 0) return a;
      if (eb == spfa_pkg::EXP_MAX && fb != 0) return b;
      if (ea == spfa_pkg::EXP_MAX && eb == spfa_pkg::EXP_MAX)
         return (sa != sb) ? spfa_pkg::QNAN_DEFAULT : a;
      if (ea == spfa_pkg::EXP_MAX) return a;
      if (eb == spfa_pkg::EXP_MAX) return b;
      if (ea == 0 && fa == 0 && eb == 0 && fb == 0) return {sa & sb, 31'd0};
      if (ea == 0 && fa == 0) return b;
      if (eb == 0 && fb == 0) return a;
      ma = {40'd0, (ea != 0), fa} << 30;
      mb = {40'd0, (eb != 0), fb} << 30;
      xa = (ea != 0) ? int'(ea) : 1;
      xb = (eb != 0) ? int'(eb) : 1;
      // Larger magnitude goes first.
      if (xb > xa || (xb == xa && mb > ma)) begin
         tm = ma; ma = mb; mb = tm;
         tx = xa; xa = xb; xb = tx;
         ts = sa; sa = sb; sb = ts;
      end
      d = xa - xb;
      if (d >= 63) begin
         mb = (mb != 0) ? 64'd1 : 64'd0;
      end else if (d > 0) begin
         lost = mb & ((64'd1 << d) - 1);
         mb = mb >> d;
         if (lost != 0) mb = mb | 64'd1;
      end
      r = (sa == sb) ? ma + mb : ma - mb;
      if (r == 0) return 32'd0;
      sgn = sa;
      p = -1;
      for (int i = 0; i < 64; i++) if (r[i]) p = i;
      e = xa + p - 53;
      if (e >= 1) begin
         s = p - 23;
         eenc = 32'(e - 1);
      end else begin
         s = 31 - xa;
         eenc = 32'd0;
      end
      if (s <= 0) begin
         m = (-s < 40) ? (r << (-s)) : 64'd0;
      end else if (s >= 63) begin
         m = 64'd0;
      end else begin
         rem = r & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         m = r >> s;
         if (rem > half || (rem == half && m[0])) m = m + 64'd1;
      end
      packed_val = ({32'd0, eenc} << 23) + m;
      if (packed_val >= 64'h7F80_0000) return {sgn, spfa_pkg::INF_PACKED[30:0]};
      return {sgn, packed_val[30:0]};
   endfunction

   // Send one request, with its expected sum queued at acceptance.
   task automatic send_pair(logic [31:0] a, logic [31:0] b);
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sum_queue.push_back(float_sum(a, b));
      sent_count++;
      @(negedge clock);
   endtask

   // Drop valid for a random gap after a burst.
   task automatic burst_gap();
      if ($urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Receiver stalls in runs of its own.
   always @(negedge clock) begin
      if (reset || !stall_enable) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 9) < 3) rsp_tready <= ~rsp_tready;
   end

   // Compare each accepted sum with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sum_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected sum %h", rsp_tdata);
         end else begin
            logic [31:0] want;
            want = sum_queue.pop_front();
            sum_count++;
            if (want !== rsp_tdata) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("sum mismatch: expected %h got %h", want, rsp_tdata);
            end
         end
      end
   end

   // Random operand biased toward interesting classes.
   function automatic logic [31:0] pick_operand(logic [31:0] other);
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v[30:23] = 8'h00;
         1: v[30:23] = 8'hFF;
         2: v[30:23] = other[30:23] + 8'($urandom_range(0, 3)) - 8'd1;
         3: v = {~other[31], other[30:0]} ^ {9'd0, 23'($urandom_range(0, 3))};
         4: v[30:23] = 8'($urandom_range(8'hF8, 8'hFE));
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_special_operands();
      logic [31:0] ops[$];
      ops = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0001, 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF,
              32'h7F7F_FFFF, 32'h3F80_0000};
      foreach (ops[i]) send_pair(ops[i], ops[(i + 3) % ops.size()]);
      send_pair(32'h7F80_0000, 32'hFF80_0000);
      send_pair(32'hFF80_0000, 32'hFF80_0000);
      send_pair(32'hFF80_0001, 32'h7FC0_0000);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h3F80_0000, 32'hBF80_0000);
      send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
      send_pair(32'h0040_0000, 32'h0040_0000);
      send_pair(32'h007F_FFFF, 32'h0000_0001);
      send_pair(32'h3F80_0000, 32'h3380_0000);
      send_pair(32'h3F80_0000, 32'h3380_0001);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   task automatic test_random_sums();
      logic [31:0] a;
      stall_enable = 1'b1;
      for (int n = 0; n < 2000; n++) begin
         a = $urandom;
         send_pair(a, pick_operand(a));
         if (n > 600 && n < 1200) continue;   // long stretch with no gaps
         burst_gap();
      end
      req_tvalid <= 1'b0;
   endtask

   // Time limit for the whole run.
   initial begin
      #2_000_000;
      $display("tb failed");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      stall_enable   = 1'b0;
      mismatch_count = 0;
      sum_count      = 0;
      sent_count     = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_special_operands();
      test_random_sums();
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d operand pairs (special values, subnormals, random), checked %0d sums.",
               sent_count, sum_count);
      $display("Mismatches: %0d.", mismatch_count);
      if (mismatch_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule
